// ----- rtl/ant_pkg.sv -----
// Shared types and constants of the active note table.
package ant_pkg;

    localparam int NOTE_SLOTS  = 16;
    localparam int SLOT_W      = $clog2(NOTE_SLOTS);
    localparam int COUNT_W     = $clog2(NOTE_SLOTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [COUNT_W-1:0]     COUNT_MAX  = COUNT_W'(NOTE_SLOTS);
    localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    localparam logic [2:0] MODE_NOTE_ON  = 3'd0;
    localparam logic [2:0] MODE_NOTE_OFF = 3'd1;
    localparam logic [2:0] MODE_TICK     = 3'd2;
    localparam logic [2:0] MODE_ALL_OFF  = 3'd3;
    localparam logic [2:0] MODE_PEDAL    = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIDI_CHANNEL  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_ENABLE = 1'b1;

    localparam logic MSG_NOTE_OFF = 1'b0;
    localparam logic MSG_NOTE_ON  = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] pitch;
        logic [6:0] velocity;
        logic [7:0] length;
        logic       tie;
        logic       chord_start;
        logic       pedal_value;
    } t_item;

    typedef struct packed {
        logic       message_kind;
        logic [6:0] out_pitch;
        logic [6:0] out_velocity;
        logic [3:0] out_channel;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [6:0] pitch;
        logic [6:0] velocity;
        logic [7:0] length;
        logic       tie;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    typedef enum logic [1:0] {
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_TICK,
        OP_ALL_OFF
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       sweep;
        logic [6:0] pitch;
        logic [6:0] velocity;
        logic [7:0] length;
        logic       tie;
    } t_cmd;

    typedef struct packed {
        logic       kind;
        logic [6:0] pitch;
        logic [6:0] velocity;
    } t_msg;

    typedef struct packed {
        logic emit;
        logic done;
        t_msg msg;
    } t_emit;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_MOVE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SRCH_MOVE,
        ST_STORE,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_FINISH
    } t_eng_state;

endpackage

// ----- rtl/ant_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ant_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ant_front.sv -----
// Front end: accepts input items, tracks the pedal and queues table commands.
module ant_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  ant_pkg::t_item        i_item,
    output logic                  o_cmd_valid,
    output ant_pkg::t_cmd         o_cmd,
    input  logic                  i_cmd_take
);

    logic                            r_pedal;
    ant_pkg::t_cmd                   r_q [ant_pkg::QUEUE_DEPTH];
    logic [ant_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [ant_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [ant_pkg::QUEUE_CNT_W-1:0] r_q_count;
    logic [ant_pkg::QUEUE_CNT_W-1:0] n_q_count;

    logic          accept;
    logic          enq;
    logic          is_cmd;
    ant_pkg::t_cmd cmd;

    assign full        = (r_q_count == ant_pkg::QUEUE_FULL);
    assign accept      = push && !full;
    assign enq         = accept && is_cmd;
    assign o_cmd_valid = (r_q_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        is_cmd       = 1'b0;
        cmd.op       = ant_pkg::OP_NOTE_ON;
        cmd.sweep    = 1'b0;
        cmd.pitch    = i_item.pitch;
        cmd.velocity = i_item.velocity;
        cmd.length   = i_item.length;
        cmd.tie      = i_item.tie;
        unique case (i_item.mode)
            ant_pkg::MODE_NOTE_ON: begin
                is_cmd    = 1'b1;
                cmd.op    = ant_pkg::OP_NOTE_ON;
                cmd.sweep = i_item.chord_start && !r_pedal;
            end
            ant_pkg::MODE_NOTE_OFF: begin
                is_cmd = 1'b1;
                cmd.op = ant_pkg::OP_NOTE_OFF;
            end
            ant_pkg::MODE_TICK: begin
                is_cmd    = 1'b1;
                cmd.op    = ant_pkg::OP_TICK;
                cmd.sweep = !r_pedal;
            end
            ant_pkg::MODE_ALL_OFF: begin
                is_cmd    = 1'b1;
                cmd.op    = ant_pkg::OP_ALL_OFF;
                cmd.sweep = 1'b1;
            end
            default: begin
                is_cmd = 1'b0;
            end
        endcase
    end

    always_comb begin
        case ({enq, i_cmd_take})
            2'b10:   n_q_count = r_q_count + 1'b1;
            2'b01:   n_q_count = r_q_count - 1'b1;
            default: n_q_count = r_q_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pedal   <= 1'b0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
        end else begin
            if (accept && i_item.mode == ant_pkg::MODE_PEDAL) begin
                r_pedal <= i_item.pedal_value;
            end
            if (enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_q_count <= n_q_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

// ----- rtl/ant_engine.sv -----
// Back end: sequencer that walks the note table and produces messages.
module ant_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  ant_pkg::t_cmd  i_cmd,
    output logic           o_cmd_take,
    input  logic           i_out_ready,
    output ant_pkg::t_emit o_emit
);

    ant_pkg::t_eng_state         r_state;
    ant_pkg::t_eng_state         n_state;
    ant_pkg::t_cmd               r_cmd;
    ant_pkg::t_cmd               n_cmd;
    logic [ant_pkg::COUNT_W-1:0] r_idx;
    logic [ant_pkg::COUNT_W-1:0] n_idx;
    logic [ant_pkg::COUNT_W-1:0] r_count;
    logic [ant_pkg::COUNT_W-1:0] n_count;

    logic                          ram_we;
    logic [ant_pkg::SLOT_W-1:0]    ram_waddr;
    ant_pkg::t_slot                ram_wdata;
    logic [ant_pkg::SLOT_W-1:0]    ram_raddr;
    logic [ant_pkg::SLOT_BITS-1:0] ram_rdata;
    ant_pkg::t_slot                rd;

    logic [ant_pkg::COUNT_W-1:0] idx_m1;
    logic [ant_pkg::COUNT_W-1:0] last_pos;
    logic                        scan_hit;
    logic                        pitch_hit;
    ant_pkg::t_eng_state         after_srch;

    ant_ram #(
        .WIDTH (ant_pkg::SLOT_BITS),
        .DEPTH (ant_pkg::NOTE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd        = ant_pkg::t_slot'(ram_rdata);
    assign idx_m1    = r_idx - 1'b1;
    assign last_pos  = r_count - 1'b1;
    assign pitch_hit = (rd.pitch == r_cmd.pitch);
    assign after_srch = (r_cmd.op == ant_pkg::OP_NOTE_ON) ? ant_pkg::ST_STORE
                                                          : ant_pkg::ST_FINISH;

    always_comb begin
        case (r_cmd.op)
            ant_pkg::OP_NOTE_ON: scan_hit = rd.tie;
            ant_pkg::OP_TICK:    scan_hit = (rd.length == '0);
            ant_pkg::OP_ALL_OFF: scan_hit = 1'b1;
            default:             scan_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ant_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        ant_pkg::OP_NOTE_ON:
                            n_state = i_cmd.sweep ? ant_pkg::ST_SCAN_RD : ant_pkg::ST_SRCH_RD;
                        ant_pkg::OP_NOTE_OFF: n_state = ant_pkg::ST_SRCH_RD;
                        ant_pkg::OP_TICK:     n_state = ant_pkg::ST_DEC_RD;
                        ant_pkg::OP_ALL_OFF:  n_state = ant_pkg::ST_SCAN_RD;
                        default:              n_state = ant_pkg::ST_IDLE;
                    endcase
                end
            end
            ant_pkg::ST_SCAN_RD: begin
                if (r_idx == '0) begin
                    n_state = (r_cmd.op == ant_pkg::OP_NOTE_ON) ? ant_pkg::ST_SRCH_RD
                                                                : ant_pkg::ST_FINISH;
                end else begin
                    n_state = ant_pkg::ST_SCAN_CHK;
                end
            end
            ant_pkg::ST_SCAN_CHK: begin
                if (!scan_hit) begin
                    n_state = ant_pkg::ST_SCAN_RD;
                end else if (i_out_ready) begin
                    n_state = (r_idx == r_count) ? ant_pkg::ST_SCAN_RD : ant_pkg::ST_SCAN_MOVE;
                end
            end
            ant_pkg::ST_SCAN_MOVE: n_state = ant_pkg::ST_SCAN_RD;
            ant_pkg::ST_SRCH_RD: begin
                if (r_idx == r_count) begin
                    if (r_cmd.op == ant_pkg::OP_NOTE_OFF) begin
                        if (i_out_ready) begin
                            n_state = ant_pkg::ST_FINISH;
                        end
                    end else begin
                        n_state = ant_pkg::ST_STORE;
                    end
                end else begin
                    n_state = ant_pkg::ST_SRCH_CHK;
                end
            end
            ant_pkg::ST_SRCH_CHK: begin
                if (!pitch_hit) begin
                    n_state = ant_pkg::ST_SRCH_RD;
                end else if (i_out_ready) begin
                    n_state = (r_idx == last_pos) ? after_srch : ant_pkg::ST_SRCH_MOVE;
                end
            end
            ant_pkg::ST_SRCH_MOVE: n_state = after_srch;
            ant_pkg::ST_STORE: begin
                if (r_cmd.velocity == '0 || i_out_ready) begin
                    n_state = ant_pkg::ST_FINISH;
                end
            end
            ant_pkg::ST_DEC_RD: begin
                if (r_idx == r_count) begin
                    n_state = r_cmd.sweep ? ant_pkg::ST_SCAN_RD : ant_pkg::ST_FINISH;
                end else begin
                    n_state = ant_pkg::ST_DEC_WR;
                end
            end
            ant_pkg::ST_DEC_WR: n_state = ant_pkg::ST_DEC_RD;
            ant_pkg::ST_FINISH: begin
                if (i_out_ready) begin
                    n_state = ant_pkg::ST_IDLE;
                end
            end
            default: n_state = ant_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_count    = r_count;
        o_cmd_take = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_m1[ant_pkg::SLOT_W-1:0];
        ram_wdata  = rd;
        ram_raddr  = idx_m1[ant_pkg::SLOT_W-1:0];
        o_emit     = '0;
        unique case (r_state)
            ant_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    if ((i_cmd.op == ant_pkg::OP_NOTE_ON && i_cmd.sweep) ||
                        i_cmd.op == ant_pkg::OP_ALL_OFF) begin
                        n_idx = r_count;
                    end else begin
                        n_idx = '0;
                    end
                end
            end
            ant_pkg::ST_SCAN_RD: begin
                if (r_idx == '0) begin
                    n_idx = '0;
                end
            end
            ant_pkg::ST_SCAN_CHK: begin
                if (!scan_hit) begin
                    n_idx = idx_m1;
                end else if (i_out_ready) begin
                    o_emit.emit         = 1'b1;
                    o_emit.msg.kind     = ant_pkg::MSG_NOTE_OFF;
                    o_emit.msg.pitch    = rd.pitch;
                    o_emit.msg.velocity = '0;
                    n_count             = last_pos;
                    if (r_idx == r_count) begin
                        n_idx = idx_m1;
                    end else begin
                        ram_raddr = last_pos[ant_pkg::SLOT_W-1:0];
                    end
                end
            end
            ant_pkg::ST_SCAN_MOVE: begin
                ram_we = 1'b1;
                n_idx  = idx_m1;
            end
            ant_pkg::ST_SRCH_RD: begin
                ram_raddr = r_idx[ant_pkg::SLOT_W-1:0];
                if (r_idx == r_count && r_cmd.op == ant_pkg::OP_NOTE_OFF && i_out_ready) begin
                    o_emit.emit         = 1'b1;
                    o_emit.msg.kind     = ant_pkg::MSG_NOTE_OFF;
                    o_emit.msg.pitch    = r_cmd.pitch;
                    o_emit.msg.velocity = '0;
                end
            end
            ant_pkg::ST_SRCH_CHK: begin
                ram_raddr = r_idx[ant_pkg::SLOT_W-1:0];
                if (!pitch_hit) begin
                    n_idx = r_idx + 1'b1;
                end else if (i_out_ready) begin
                    o_emit.emit         = 1'b1;
                    o_emit.msg.kind     = ant_pkg::MSG_NOTE_OFF;
                    o_emit.msg.pitch    = r_cmd.pitch;
                    o_emit.msg.velocity = '0;
                    n_count             = last_pos;
                    if (r_idx != last_pos) begin
                        ram_raddr = last_pos[ant_pkg::SLOT_W-1:0];
                    end
                end
            end
            ant_pkg::ST_SRCH_MOVE: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[ant_pkg::SLOT_W-1:0];
            end
            ant_pkg::ST_STORE: begin
                if (r_cmd.velocity != '0 && i_out_ready) begin
                    o_emit.emit         = 1'b1;
                    o_emit.msg.kind     = ant_pkg::MSG_NOTE_ON;
                    o_emit.msg.pitch    = r_cmd.pitch;
                    o_emit.msg.velocity = r_cmd.velocity;
                    if (r_count < ant_pkg::COUNT_MAX) begin
                        ram_we             = 1'b1;
                        ram_waddr          = r_count[ant_pkg::SLOT_W-1:0];
                        ram_wdata.pitch    = r_cmd.pitch;
                        ram_wdata.velocity = r_cmd.velocity;
                        ram_wdata.length   = r_cmd.length;
                        ram_wdata.tie      = r_cmd.tie;
                        n_count            = r_count + 1'b1;
                    end
                end
            end
            ant_pkg::ST_DEC_RD: begin
                ram_raddr = r_idx[ant_pkg::SLOT_W-1:0];
                if (r_idx == r_count) begin
                    n_idx = r_count;
                end
            end
            ant_pkg::ST_DEC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[ant_pkg::SLOT_W-1:0];
                if (rd.length != '0) begin
                    ram_wdata.length = rd.length - 1'b1;
                end
                n_idx = r_idx + 1'b1;
            end
            ant_pkg::ST_FINISH: begin
                o_emit.done = i_out_ready;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ant_pkg::ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ant_pkg::COUNT_MAX)
        else $error("slot count above table size");

    a_emit_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.emit || o_emit.done) |-> (i_out_ready && !(o_emit.emit && o_emit.done)))
        else $error("message or completion without room in result queue");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.done |=> (r_state == ant_pkg::ST_IDLE))
        else $error("sequencer not idle after completing an item");
`endif

endmodule

// ----- rtl/ant_out.sv -----
// Result side: marks the final message of each item and queues results.
module ant_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ant_pkg::t_emit  i_emit,
    output logic            o_ready,
    input  logic            i_enable,
    input  logic [3:0]      i_channel,
    output logic            empty,
    input  logic            pop,
    output ant_pkg::t_result o_result
);

    logic                            r_hold_valid;
    logic                            n_hold_valid;
    ant_pkg::t_msg                   r_hold;
    ant_pkg::t_result                r_q [ant_pkg::QUEUE_DEPTH];
    logic [ant_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [ant_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [ant_pkg::QUEUE_CNT_W-1:0] r_q_count;
    logic [ant_pkg::QUEUE_CNT_W-1:0] n_q_count;

    logic             take_msg;
    logic             enq;
    logic             deq;
    ant_pkg::t_result enq_data;

    assign take_msg = i_emit.emit && i_enable;
    assign empty    = (r_q_count == '0);
    assign deq      = pop && !empty;
    assign o_ready  = (r_q_count != ant_pkg::QUEUE_FULL);
    assign o_result = r_q[r_rd_ptr];

    always_comb begin
        enq                   = 1'b0;
        n_hold_valid          = r_hold_valid;
        enq_data.message_kind = r_hold.kind;
        enq_data.out_pitch    = r_hold.pitch;
        enq_data.out_velocity = r_hold.velocity;
        enq_data.out_channel  = i_channel;
        enq_data.last         = 1'b0;
        if (take_msg) begin
            enq          = r_hold_valid;
            n_hold_valid = 1'b1;
        end else if (i_emit.done) begin
            enq           = r_hold_valid;
            enq_data.last = 1'b1;
            n_hold_valid  = 1'b0;
        end
    end

    always_comb begin
        case ({enq, deq})
            2'b10:   n_q_count = r_q_count + 1'b1;
            2'b01:   n_q_count = r_q_count - 1'b1;
            default: n_q_count = r_q_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_q_count    <= '0;
        end else begin
            r_hold_valid <= n_hold_valid;
            if (enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (deq) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_q_count <= n_q_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_msg) begin
            r_hold <= i_emit.msg;
        end
        if (enq) begin
            r_q[r_wr_ptr] <= enq_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_count == ant_pkg::QUEUE_FULL && !deq) |-> !enq)
        else $error("result queue overflow");
`endif

endmodule

// ----- rtl/active_note_table.sv -----
// Top level of the active note table: configuration registers and wiring.
//
// Input side is a queue: present an item on i_item and raise push; it is
// taken at a clock edge where full is low. Items are classified at once
// (pedal changes and unused modes finish there) and wait in a two-entry
// command queue. Results come out as a queue: while empty is low the oldest
// note-on or note-off message sits on o_result; pop takes it. The last flag
// marks the final message of an item.
// The table lives in a 16-entry RAM walked by a sequencer, one read per
// visited slot. Releasing an entry that is not the top one adds a move
// step that copies the top entry into its place.
// When pop stays low, the two-entry result queue fills and the sequencer
// holds; the command queue then fills and full rises.
// Configuration writes (cfg_valid, always ready) set the channel and the
// output enable; write them only while no item is in flight.
// Reset empties both queues and the table, releases the pedal, sets
// channel 0 and enables output.
module active_note_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  ant_pkg::t_item                      i_item,
    output logic                                empty,
    input  logic                                pop,
    output ant_pkg::t_result                    o_result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ant_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ant_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [3:0] r_midi_channel;
    logic       r_output_enable;

    logic           cmd_valid;
    ant_pkg::t_cmd  cmd;
    logic           cmd_take;
    logic           out_ready;
    ant_pkg::t_emit emit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi_channel  <= '0;
            r_output_enable <= 1'b1;
        end else if (cfg_valid) begin
            unique case (i_cfg_index)
                ant_pkg::CFG_MIDI_CHANNEL:  r_midi_channel  <= i_cfg_data[3:0];
                ant_pkg::CFG_OUTPUT_ENABLE: r_output_enable <= i_cfg_data[0];
            endcase
        end
    end

    ant_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    ant_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_out_ready (out_ready),
        .o_emit      (emit)
    );

    ant_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_emit    (emit),
        .o_ready   (out_ready),
        .i_enable  (r_output_enable),
        .i_channel (r_midi_channel),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the active note table: queue-style driving and message prediction.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ant_pkg::*;

    localparam int          ITEM_W        = $bits(t_item);
    localparam int          POOL_SPAN     = 24;
    localparam int          FILL_NOTES    = NOTE_SLOTS + 2;
    localparam int          SETTLE_CYCLES = 400;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam logic [2:0]  MODE_CODE_TOP = 3'd7;

    class note_board;
        t_slot            slots [NOTE_SLOTS];
        int               held;
        logic             pedal_down;
        logic [3:0]       channel;
        logic             out_on;
        t_result          due_msgs [$];
        t_result          item_msgs [$];
        int               mismatches;

        function new();
            held       = 0;
            pedal_down = 1'b0;
            channel    = '0;
            out_on     = 1'b1;
            mismatches = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MIDI_CHANNEL) begin
                channel = data[3:0];
            end else if (idx == CFG_OUTPUT_ENABLE) begin
                out_on = data[0];
            end
        endfunction

        function void send_msg(logic kind, logic [6:0] p, logic [6:0] v);
            t_result m;
            if (!out_on) return;
            m.message_kind = kind;
            m.out_pitch    = p;
            m.out_velocity = v;
            m.out_channel  = channel;
            m.last         = 1'b0;
            item_msgs.push_back(m);
        endfunction

        function bit drop_pitch(logic [6:0] p);
            for (int i = 0; i < held; i++) begin
                if (slots[i].pitch == p) begin
                    slots[i] = slots[held-1];
                    held--;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void free_note(logic [6:0] p);
            send_msg(MSG_NOTE_OFF, p, '0);
            void'(drop_pitch(p));
        endfunction

        function void keep_note(logic [6:0] p, logic [6:0] v, logic [7:0] len, logic tie_mark);
            for (int i = 0; i < held; i++) begin
                if (slots[i].pitch == p) begin
                    slots[i].velocity = v;
                    slots[i].length   = len;
                    slots[i].tie      = tie_mark;
                    return;
                end
            end
            if (held >= NOTE_SLOTS) return;
            slots[held].pitch    = p;
            slots[held].velocity = v;
            slots[held].length   = len;
            slots[held].tie      = tie_mark;
            held++;
        endfunction

        function void play_item(t_item it);
            item_msgs.delete();
            case (it.mode)
                MODE_NOTE_ON: begin
                    if (it.chord_start && !pedal_down) begin
                        for (int i = held; i > 0; i--) begin
                            if (i - 1 < held && slots[i-1].tie) free_note(slots[i-1].pitch);
                        end
                    end
                    if (drop_pitch(it.pitch)) send_msg(MSG_NOTE_OFF, it.pitch, '0);
                    if (it.velocity != '0) begin
                        send_msg(MSG_NOTE_ON, it.pitch, it.velocity);
                        keep_note(it.pitch, it.velocity, it.length, it.tie);
                    end
                end
                MODE_NOTE_OFF: begin
                    free_note(it.pitch);
                end
                MODE_TICK: begin
                    for (int i = 0; i < held; i++) begin
                        if (slots[i].length != '0) slots[i].length = slots[i].length - 8'd1;
                    end
                    if (!pedal_down) begin
                        for (int i = held; i > 0; i--) begin
                            if (i - 1 < held && slots[i-1].length == '0) begin
                                free_note(slots[i-1].pitch);
                            end
                        end
                    end
                end
                MODE_ALL_OFF: begin
                    for (int i = held; i > 0; i--) begin
                        if (i - 1 < held) free_note(slots[i-1].pitch);
                    end
                end
                MODE_PEDAL: begin
                    pedal_down = it.pedal_value;
                end
                default: begin
                end
            endcase
            if (item_msgs.size() > 0) item_msgs[item_msgs.size()-1].last = 1'b1;
            foreach (item_msgs[i]) due_msgs.push_back(item_msgs[i]);
        endfunction

        function void match_message(t_result got);
            t_result want;
            if (due_msgs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected message: kind %0d pitch %0d vel %0d ch %0d last %0d",
                             got.message_kind, got.out_pitch, got.out_velocity,
                             got.out_channel, got.last);
                return;
            end
            want = due_msgs.pop_front();
            if (got.message_kind !== want.message_kind || got.out_pitch !== want.out_pitch ||
                got.out_velocity !== want.out_velocity || got.out_channel !== want.out_channel ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected kind %0d pitch %0d vel %0d ch %0d last %0d, %s",
                             want.message_kind, want.out_pitch, want.out_velocity,
                             want.out_channel, want.last,
                             $sformatf("got kind %0d pitch %0d vel %0d ch %0d last %0d",
                                       got.message_kind, got.out_pitch, got.out_velocity,
                                       got.out_channel, got.last));
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   push;
    logic                   full;
    t_item                  i_item;
    logic                   empty;
    logic                   pop;
    t_result                o_result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    note_board board;
    int        cycles = 0;
    int        send_burst;
    int        pool_base;
    bit        hold_req;

    active_note_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) board.play_item(i_item);
            if (pop && !empty) board.match_message(o_result);
            if (cfg_valid && cfg_ready) board.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    initial begin
        int stall_left;
        int burst_left;
        int r;
        stall_left = 0;
        burst_left = 0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end else if (burst_left > 0) begin
                pop <= 1'b1;
                burst_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    stall_left = $urandom_range(8, 40);
                    pop <= 1'b0;
                end else if (r < 10) begin
                    burst_left = $urandom_range(10, 40);
                    pop <= 1'b1;
                end else begin
                    pop <= (r >= 40);
                end
            end
        end
    end

    function automatic int pick_gap(inout int burst_left);
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic t_item make_item(logic [2:0] mode, logic [6:0] p, logic [6:0] v,
                                        logic [7:0] len, logic tie_mark, logic chord,
                                        logic pedal);
        t_item it;
        it.mode        = mode;
        it.pitch       = p;
        it.velocity    = v;
        it.length      = len;
        it.tie         = tie_mark;
        it.chord_start = chord;
        it.pedal_value = pedal;
        return it;
    endfunction

    function automatic t_item chord_note(bit first);
        t_item it;
        it             = ITEM_W'($urandom);
        it.mode        = MODE_NOTE_ON;
        it.pitch       = 7'(pool_base + $urandom_range(0, POOL_SPAN - 1));
        it.velocity    = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
        it.length      = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 4))
                                                      : 8'($urandom_range(0, 255));
        it.tie         = ($urandom_range(0, 99) < 30);
        it.chord_start = first ? ($urandom_range(0, 99) < 80) : ($urandom_range(0, 99) < 5);
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        i_item <= it;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        gap = pick_gap(send_burst);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic set_config(input logic [3:0] chan, input logic en);
        i_cfg_index <= CFG_MIDI_CHANNEL;
        i_cfg_data <= chan;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_OUTPUT_ENABLE;
        i_cfg_data <= {3'($urandom_range(0, 7)), en};
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        push <= 1'b0;
        while (board.due_msgs.size() != 0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_table();
        int base;
        t_item it;
        base = $urandom_range(0, 127);
        for (int k = 0; k < FILL_NOTES; k++) begin
            it             = ITEM_W'($urandom);
            it.mode        = MODE_NOTE_ON;
            it.pitch       = 7'(base + k * 5);
            it.velocity    = 7'($urandom_range(1, 127));
            it.length      = 8'($urandom_range(200, 255));
            it.chord_start = 1'b0;
            send_item(it);
        end
        it = ITEM_W'($urandom);
        it.mode = MODE_ALL_OFF;
        send_item(it);
    endtask

    task automatic play_phrase(inout int count);
        int    r;
        int    n;
        t_item it;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++) begin
                send_item(chord_note(k == 0));
                count++;
            end
        end else if (r < 75) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                it = ITEM_W'($urandom);
                it.mode = MODE_TICK;
                send_item(it);
                count++;
            end
        end else if (r < 83) begin
            it = ITEM_W'($urandom);
            it.mode = MODE_NOTE_OFF;
            it.pitch = 7'(pool_base + $urandom_range(0, POOL_SPAN - 1));
            send_item(it);
            count++;
        end else if (r < 87) begin
            it = ITEM_W'($urandom);
            it.mode = MODE_ALL_OFF;
            send_item(it);
            count++;
        end else if (r < 93) begin
            it = ITEM_W'($urandom);
            it.mode = MODE_PEDAL;
            send_item(it);
            count++;
        end else if (r < 96) begin
            it = ITEM_W'($urandom);
            it.mode = 3'($urandom_range(MODE_PEDAL + 1, MODE_CODE_TOP));
            send_item(it);
        end else begin
            it = ITEM_W'($urandom);
            send_item(it);
            if (it.mode <= MODE_PEDAL) count++;
        end
    endtask

    task automatic run_phrases(input int target);
        int count;
        count = 0;
        while (count < target) play_phrase(count);
    endtask

    initial begin
        board = new();
        send_burst = 0;
        hold_req = 1'b0;
        pool_base = 0;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_item <= '0;
        cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(4'd15, 1'b1);
        send_item(make_item(MODE_NOTE_ON, 7'd127, 7'd127, 8'd255, 1'b1, 1'b1, 1'b0));
        send_item(make_item(MODE_NOTE_ON, 7'd0, 7'd1, 8'd0, 1'b0, 1'b0, 1'b1));
        send_item(make_item(MODE_NOTE_ON, 7'd60, 7'd64, 8'd2, 1'b1, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_ON, 7'd60, 7'd100, 8'd2, 1'b1, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_ON, 7'd0, 7'd0, 8'd9, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_ON, 7'd33, 7'd0, 8'd9, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_OFF, 7'd42, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_ON, 7'd64, 7'd90, 8'd3, 1'b0, 1'b1, 1'b0));
        send_item(make_item(MODE_PEDAL, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0, 1'b1));
        repeat (3) send_item(make_item(MODE_TICK, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_ON, 7'd70, 7'd50, 8'd1, 1'b1, 1'b1, 1'b0));
        send_item(make_item(MODE_PEDAL, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_TICK, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_OFF, 7'd127, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_ALL_OFF, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_ON, 7'd85, 7'd127, 8'd255, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_NOTE_ON, 7'd42, 7'd77, 8'd1, 1'b1, 1'b0, 1'b0));
        send_item(make_item(MODE_ALL_OFF, 7'd0, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(MODE_PEDAL + 3'd1, 7'd127, 7'd127, 8'd255, 1'b1, 1'b1, 1'b1));
        send_item(make_item(MODE_CODE_TOP, 7'd5, 7'd9, 8'd1, 1'b0, 1'b1, 1'b0));
        send_item(make_item(MODE_NOTE_OFF, 7'd127, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        wait_idle();

        pool_base = $urandom_range(0, 128 - POOL_SPAN);
        fill_table();
        run_phrases(60);
        wait_idle();

        set_config(4'($urandom_range(1, 14)), 1'b0);
        pool_base = $urandom_range(0, 128 - POOL_SPAN);
        run_phrases(25);
        wait_idle();

        set_config(4'd0, 1'b1);
        pool_base = $urandom_range(0, 128 - POOL_SPAN);
        run_phrases(30);
        hold_req = 1'b1;
        run_phrases(30);
        wait_quiet();
        run_phrases(25);
        wait_idle();

        if (board.mismatches == 0 && board.due_msgs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
